/* sv/cde_pkg.sv */
// cde_pkg: shared types and constants for the circular deque engine
// no dependencies; imported by cde_ptr, circular_deque_engine and cde_checker
`default_nettype none

package cde_pkg;

    localparam int CAP_W  = 11;
    localparam int ELEM_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_CLEAR      = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        status_t          status;
        logic [CAP_W-1:0] occupancy;
        logic             is_empty;
        logic             is_full;
        logic             pop_ok;
    } res_info_t;

endpackage

`default_nettype wire

/* sv/cde_ram.sv */
// cde_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module cde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/cde_ptr.sv */
// cde_ptr: front/back indices, element count and ram access decode
// depends on cde_pkg
`default_nettype none

module cde_ptr import cde_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     go,
    input  wire logic [OP_W-1:0]          op,
    input  wire logic [CAP_W-1:0]         capacity,
    output logic                          ram_we,
    output logic                          ram_re,
    output logic      [$clog2(DEPTH)-1:0] ram_addr,
    output res_info_t                     res
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = (AW < CAP_W) ? AW : CAP_W;
    localparam int CAP_MAX = (1 << CAP_W) - 1;
    localparam logic [CAP_W-1:0] CAP_LIM = CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i, input logic [CAP_W-1:0] c);
        logic [CAP_W:0] n;
        n = (CAP_W+1)'(i) + (CAP_W+1)'(1);
        return (n >= {1'b0, c}) ? '0 : IW'(n);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i, input logic [CAP_W-1:0] c);
        logic [CAP_W-1:0] m;
        m = c - CAP_W'(1);
        return (i == '0) ? IW'(m) : i - IW'(1);
    endfunction

    logic [IW-1:0]    front_reg, front_next;
    logic [IW-1:0]    back_reg, back_next;
    logic [CAP_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0] cap_eff;
    logic [IW-1:0]    idx;
    logic             full_now;

    always_comb
    begin
        if (capacity == '0)
        begin
            cap_eff = CAP_W'(1);
        end
        else if (capacity > CAP_LIM)
        begin
            cap_eff = CAP_LIM;
        end
        else
        begin
            cap_eff = capacity;
        end
    end

    assign full_now = (count_reg >= cap_eff);

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        idx        = back_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        res.status = ST_OK;
        res.pop_ok = 1'b0;
        unique case (op_t'(op))
            OP_PUSH_BACK:
            begin
                if (full_now)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    idx        = back_reg;
                    ram_we     = go;
                    back_next  = idx_inc(back_reg, cap_eff);
                    count_next = count_reg + CAP_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    front_next = idx_dec(front_reg, cap_eff);
                    idx        = front_next;
                    ram_we     = go;
                    count_next = count_reg + CAP_W'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    back_next  = idx_dec(back_reg, cap_eff);
                    idx        = back_next;
                    ram_re     = go;
                    res.pop_ok = 1'b1;
                    count_next = count_reg - CAP_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    idx        = front_reg;
                    ram_re     = go;
                    res.pop_ok = 1'b1;
                    front_next = idx_inc(front_reg, cap_eff);
                    count_next = count_reg - CAP_W'(1);
                end
            end
            OP_CLEAR:
            begin
                front_next = '0;
                back_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
        res.occupancy = count_next;
        res.is_empty  = (count_next == '0);
        res.is_full   = (count_next >= cap_eff);
    end

    assign ram_addr = AW'(idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (go)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/circular_deque_engine.sv */
// circular_deque_engine: double-ended ring buffer over one synchronous ram
// result word passes stage s1 and the output register after the operation word is accepted
// throughput: one operation per cycle while results are taken, set by the single ram port and result stage
// reset clears front/back indices, count and pipeline valids; capacity resets to 1024
// ram contents are not cleared; depends on cde_pkg, cde_ram, cde_ptr
`default_nettype none

module circular_deque_engine import cde_pkg::*; #(
    parameter int DEPTH      = 1024,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] element_value
    input  wire logic [2:0]  s_tuser,   // [2:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // [31:0] popped_value, [42:32] occupancy,
                                        // [43] is_empty, [44] is_full, [47:45] zero
    output logic      [1:0]  m_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(DEPTH);

    logic [CAP_W-1:0]      cap_reg;
    logic                  s_go;
    logic                  out_free;
    logic                  s1_adv;
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_addr;
    logic [ELEM_WIDTH-1:0] ram_rdata;
    res_info_t             res;

    logic                  s1_valid_reg, s1_valid_next;
    res_info_t             s1_info_reg;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg;
    logic [ELEM_W-1:0]     m_popped_reg;
    logic [CAP_W-1:0]      m_occ_reg;
    logic                  m_empty_reg;
    logic                  m_full_reg;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_go     = s_tvalid && s_tready;

    cde_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (s_go),
        .op       (s_tuser),
        .capacity (cap_reg),
        .ram_we   (ram_we),
        .ram_re   (ram_re),
        .ram_addr (ram_addr),
        .res      (res)
    );

    cde_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ELEM_WIDTH'(s_tdata)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_go)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_adv)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_go)
        begin
            s1_info_reg <= res;
        end
        if (s1_adv)
        begin
            m_status_reg <= s1_info_reg.status;
            m_popped_reg <= s1_info_reg.pop_ok ? ELEM_W'(ram_rdata) : '0;
            m_occ_reg    <= s1_info_reg.occupancy;
            m_empty_reg  <= s1_info_reg.is_empty;
            m_full_reg   <= s1_info_reg.is_full;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_full_reg, m_empty_reg, m_occ_reg, m_popped_reg};
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

/* sv/cde_checker.sv */
// cde_checker: port-level checks of the circular deque engine result stream
// depends on cde_pkg; bound to circular_deque_engine
`default_nettype none

module cde_checker import cde_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[43] == (m_tdata[42:32] == 11'd0)))
        else $error("is_empty disagrees with occupancy");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[31:0] == 32'd0))
        else $error("refused operation returned data");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[44] && !m_tdata[43])
        else $error("full status without full flag");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_EMPTY) |-> m_tdata[43] && (m_tdata[42:32] == 11'd0))
        else $error("empty status with elements present");

endmodule

bind circular_deque_engine cde_checker u_cde_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// testbench for circular_deque_engine: directed table then random operation streams
// checks every result word against its directed table entry or a deque predictor; depends on cde_pkg and the block rtl
`timescale 1ns / 1ps

module testbench;
    import cde_pkg::*;

    localparam int          HALF_PERIOD  = 2;
    localparam int          SLOTS        = 1024;
    localparam int          RX_HOLD      = 400;
    localparam int          IDLE_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [2:0]  CAP_ADDR     = {REG_CAPACITY, 2'b00};
    localparam logic [2:0]  OP_RSVD_LO   = 3'd5;
    localparam logic [2:0]  OP_RSVD_HI   = 3'd7;

    typedef struct packed {
        status_t     st;
        logic [31:0] pop;
        logic [10:0] occ;
        logic        emp;
        logic        full;
    } res_t;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  op;
        logic [31:0] val;
        logic        typed;
        res_t        want;
    } row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [31:0] slot_mem [0:SLOTS-1];
    bit          slot_seen [0:SLOTS-1];
    logic [9:0]  head_idx = '0;
    logic [9:0]  tail_idx = '0;
    logic [10:0] fill_cnt = '0;
    logic [10:0] cap_reg  = CAP_RESET;

    res_t        exp_q [$];
    row_t        plan_q [$];
    int          burst_left  = 0;
    int          words_sent  = 0;
    int          words_done  = 0;
    int          fail_cnt    = 0;
    int          peak_fill   = 0;
    int          n_directed  = 0;
    int          idle_cycles = 0;
    bit          hold_req    = 1'b0;
    bit          hold_taken  = 1'b0;

    circular_deque_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [10:0] cap_in_use();
        if (cap_reg == 11'd0)
            return 11'd1;
        if (cap_reg > 11'(SLOTS))
            return 11'(SLOTS);
        return cap_reg;
    endfunction

    function automatic logic [9:0] idx_next(input logic [9:0] i, input logic [10:0] cap);
        logic [10:0] n;
        n = {1'b0, i} + 11'd1;
        return (n >= cap) ? 10'd0 : n[9:0];
    endfunction

    function automatic logic [9:0] idx_prev(input logic [9:0] i, input logic [10:0] cap);
        logic [10:0] c;
        c = cap - 11'd1;
        return (i == 10'd0) ? c[9:0] : i - 10'd1;
    endfunction

    task automatic deque_apply(input logic [2:0] op, input logic [31:0] val, output res_t r);
        logic [10:0] cap;
        cap  = cap_in_use();
        r    = '0;
        r.st = ST_OK;
        case (op)
            OP_PUSH_BACK:
                if (fill_cnt >= cap)
                    r.st = ST_FULL;
                else
                begin
                    slot_mem[tail_idx]  = val;
                    slot_seen[tail_idx] = 1'b1;
                    tail_idx = idx_next(tail_idx, cap);
                    fill_cnt = fill_cnt + 11'd1;
                end
            OP_PUSH_FRONT:
                if (fill_cnt >= cap)
                    r.st = ST_FULL;
                else
                begin
                    head_idx = idx_prev(head_idx, cap);
                    slot_mem[head_idx]  = val;
                    slot_seen[head_idx] = 1'b1;
                    fill_cnt = fill_cnt + 11'd1;
                end
            OP_POP_BACK:
                if (fill_cnt == 11'd0)
                    r.st = ST_EMPTY;
                else
                begin
                    tail_idx = idx_prev(tail_idx, cap);
                    r.pop    = slot_mem[tail_idx];
                    fill_cnt = fill_cnt - 11'd1;
                end
            OP_POP_FRONT:
                if (fill_cnt == 11'd0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.pop    = slot_mem[head_idx];
                    head_idx = idx_next(head_idx, cap);
                    fill_cnt = fill_cnt - 11'd1;
                end
            OP_CLEAR:
            begin
                head_idx = '0;
                tail_idx = '0;
                fill_cnt = '0;
            end
            default:
                ;
        endcase
        r.occ  = fill_cnt;
        r.emp  = (fill_cnt == 11'd0);
        r.full = (fill_cnt >= cap);
        if (int'(fill_cnt) > peak_fill)
            peak_fill = int'(fill_cnt);
    endtask

    // a pop must never read a slot that was never written
    function automatic bit pop_reads_written(input logic [2:0] op);
        if (fill_cnt == 11'd0)
            return 1'b1;
        if (op == OP_POP_BACK)
            return slot_seen[idx_prev(tail_idx, cap_in_use())];
        if (op == OP_POP_FRONT)
            return slot_seen[head_idx];
        return 1'b1;
    endfunction

    task automatic plan_op(input logic [2:0] op, input logic [31:0] val);
        row_t w;
        w     = '0;
        w.op  = op;
        w.val = val;
        plan_q.push_back(w);
    endtask

    task automatic plan_chk(input logic [2:0] op, input logic [31:0] val, input status_t st,
                            input logic [31:0] pop, input logic [10:0] occ,
                            input logic emp, input logic full);
        row_t w;
        w           = '0;
        w.op        = op;
        w.val       = val;
        w.typed     = 1'b1;
        w.want.st   = st;
        w.want.pop  = pop;
        w.want.occ  = occ;
        w.want.emp  = emp;
        w.want.full = full;
        plan_q.push_back(w);
    endtask

    task automatic plan_cfg(input logic [10:0] cap);
        row_t w;
        w        = '0;
        w.is_cfg = 1'b1;
        w.val    = {21'd0, cap};
        plan_q.push_back(w);
    endtask

    task automatic send_word(input row_t w);
        int   gap;
        res_t r;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= w.op;
        s_tdata  <= w.val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        deque_apply(w.op, w.val, r);
        exp_q.push_back(w.typed ? w.want : r);
        words_sent++;
    endtask

    // drop valid and let every result drain before touching the register
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [10:0] cap);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {21'd0, cap};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cap_reg = cap;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [2:0] pick_op(input int push_pct, input int clr_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 3'($urandom_range(int'(OP_RSVD_LO), int'(OP_RSVD_HI)));
        if (r < 2 + clr_pct)
            return OP_CLEAR;
        if (r < 2 + clr_pct + push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input logic [10:0] cap, input bit with_clear, input int n,
                             input int push_pct, input int clr_pct, input bit with_hold);
        row_t w;
        settle();
        cfg_write(cap);
        if (with_clear)
        begin
            w    = '0;
            w.op = OP_CLEAR;
            send_word(w);
        end
        if (with_hold)
            hold_req = 1'b1;
        repeat (n)
        begin
            w     = '0;
            w.op  = pick_op(push_pct, clr_pct);
            w.val = pick_value();
            if (!pop_reads_written(w.op))
                w.op = OP_PUSH_BACK;
            send_word(w);
        end
    endtask

    // receiver stall patterns, plus one long hold-off
    initial
    begin : receiver
        int mode;
        int stretch;
        int tick;
        mode    = 0;
        stretch = 0;
        tick    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD) @(negedge clk);
            end
            if (stretch == 0)
            begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(10, 120);
            end
            stretch--;
            tick++;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                2: m_tready <= (tick % 4 == 0);
                default: m_tready <= (tick % 8 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t act;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            act.st   = status_t'(m_tuser);
            act.pop  = m_tdata[31:0];
            act.occ  = m_tdata[42:32];
            act.emp  = m_tdata[43];
            act.full = m_tdata[44];
            words_done++;
            if (exp_q.size() == 0)
            begin
                $display("%0t: unexpected result word st=%0d pop=%h occ=%0d empty=%0b full=%0b",
                         $time, act.st, act.pop, act.occ, act.emp, act.full);
                fail_cnt++;
            end
            else
            begin
                want = exp_q.pop_front();
                if (act !== want)
                begin
                    $display("%0t: mismatch expected st=%0d pop=%h occ=%0d empty=%0b full=%0b",
                             $time, want.st, want.pop, want.occ, want.emp, want.full);
                    $display("%0t:          actual   st=%0d pop=%h occ=%0d empty=%0b full=%0b",
                             $time, act.st, act.pop, act.occ, act.emp, act.full);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, exp_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty deque at reset capacity
        plan_chk(OP_POP_BACK,   32'h1111_1111, ST_EMPTY, 32'd0, 11'd0, 1'b1, 1'b0);
        plan_chk(OP_POP_FRONT,  32'h2222_2222, ST_EMPTY, 32'd0, 11'd0, 1'b1, 1'b0);
        plan_chk(OP_RSVD_LO,    32'h3333_3333, ST_OK,    32'd0, 11'd0, 1'b1, 1'b0);
        plan_chk(OP_RSVD_HI,    32'hFFFF_FFFF, ST_OK,    32'd0, 11'd0, 1'b1, 1'b0);
        plan_chk(OP_PUSH_BACK,  32'hFFFF_FFFF, ST_OK,    32'd0, 11'd1, 1'b0, 1'b0);
        plan_chk(OP_PUSH_FRONT, 32'h0000_0000, ST_OK,    32'd0, 11'd2, 1'b0, 1'b0);
        plan_op(OP_PUSH_FRONT,  32'hA5A5_A5A5);
        plan_chk(OP_POP_BACK,   32'h0,         ST_OK,    32'hFFFF_FFFF, 11'd2, 1'b0, 1'b0);
        plan_op(OP_POP_FRONT,   32'h0);
        plan_chk(OP_CLEAR,      32'h0,         ST_OK,    32'd0, 11'd0, 1'b1, 1'b0);
        // two slots: fill, refuse, drain
        plan_cfg(11'd2);
        plan_op(OP_PUSH_BACK,   32'h1234_5678);
        plan_op(OP_PUSH_BACK,   32'h8765_4321);
        plan_chk(OP_PUSH_FRONT, 32'h5555_5555, ST_FULL,  32'd0, 11'd2, 1'b0, 1'b1);
        plan_chk(OP_PUSH_BACK,  32'hAAAA_AAAA, ST_FULL,  32'd0, 11'd2, 1'b0, 1'b1);
        plan_op(OP_POP_FRONT,   32'h0);
        plan_op(OP_POP_FRONT,   32'h0);
        plan_chk(OP_POP_BACK,   32'h0,         ST_EMPTY, 32'd0, 11'd0, 1'b1, 1'b0);
        // zero capacity behaves as one slot
        plan_cfg(11'd0);
        plan_chk(OP_CLEAR,      32'h0,         ST_OK,    32'd0, 11'd0, 1'b1, 1'b0);
        plan_chk(OP_PUSH_FRONT, 32'hDEAD_BEEF, ST_OK,    32'd0, 11'd1, 1'b0, 1'b1);
        plan_chk(OP_PUSH_BACK,  32'hCAFE_F00D, ST_FULL,  32'd0, 11'd1, 1'b0, 1'b1);
        plan_chk(OP_POP_BACK,   32'h0,         ST_OK,    32'hDEAD_BEEF, 11'd0, 1'b1, 1'b0);
        // oversized capacity clamps to the full store
        plan_cfg(11'd2047);
        plan_chk(OP_CLEAR,      32'h0,         ST_OK,    32'd0, 11'd0, 1'b1, 1'b0);
        plan_op(OP_PUSH_BACK,   32'h0F0F_0F0F);

        foreach (plan_q[i])
        begin
            if (plan_q[i].is_cfg)
            begin
                settle();
                cfg_write(plan_q[i].val[10:0]);
            end
            else
                send_word(plan_q[i]);
        end
        n_directed = words_sent;

        run_phase(11'd3,    1'b1, 20,   50, 2, 1'b0);
        run_phase(11'd1,    1'b1, 15,   50, 2, 1'b0);
        run_phase(11'd12,   1'b1, 25,   50, 2, 1'b0);
        // fill the whole store, with the receiver held off early on
        run_phase(11'd2047, 1'b1, 1070, 98, 0, 1'b1);
        // shrink without clearing: occupancy above capacity
        run_phase(11'd5,    1'b0, 20,   40, 0, 1'b0);
        run_phase(11'd0,    1'b0, 15,   45, 3, 1'b0);
        run_phase(11'd1024, 1'b0, 15,   50, 2, 1'b0);
        run_phase(11'($urandom_range(2, 40)), 1'b0, 20, 50, 2, 1'b0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d operation words (%0d directed), %0d results checked, %0d mismatches",
                 words_sent, n_directed, words_done, fail_cnt);
        $display("capacities 0 to 2047 written, deepest fill %0d words", peak_fill);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
sv/cde_pkg.sv
sv/cde_ram.sv
sv/cde_ptr.sv
sv/circular_deque_engine.sv
sv/cde_checker.sv
test/testbench.sv
